>>> rtl/core/shmc_pkg.sv
`default_nettype none

package shmc_pkg;

    localparam int unsigned DEG_W     = 16;
    localparam int unsigned SPR_W     = 13;
    localparam int unsigned TPS_W     = 16;
    localparam int unsigned STEPS_W   = 20;
    localparam int unsigned PROD_W    = DEG_W + SPR_W;
    localparam int unsigned QUOT_W    = 21;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [SPR_W-1:0] SPR_RESET = SPR_W'(4076);
    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(10);

    localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

    // Command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REV_STEPS      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP = CFG_IDX_W'(1);

    // Division by 360 is done as a shift by 3 and then a multiply by the
    // rounded-up reciprocal of 45 scaled by 2^32; exact for 26-bit dividends.
    localparam int unsigned      RECIP_SHIFT = 32;
    localparam int unsigned      RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP_45  = RECIP_W'(95443718);

    function automatic logic [3:0] coil_of(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/shmc_step_calc.sv
`default_nettype none

module shmc_step_calc (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_cmd,
    input  wire logic                            i_direction,
    input  wire logic [shmc_pkg::DEG_W-1:0]      i_degrees,
    input  wire logic [shmc_pkg::SPR_W-1:0]      i_rev_steps,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_cmd,
    output logic                                 o_direction,
    output logic [shmc_pkg::QUOT_W-1:0]          o_steps
);

    localparam int unsigned X_W    = shmc_pkg::PROD_W - 3;
    localparam int unsigned FULL_W = X_W + shmc_pkg::RECIP_W;

    logic                          r_s1_valid;
    logic                          r_s1_cmd;
    logic                          r_s1_dir;
    logic [shmc_pkg::PROD_W-1:0]   r_s1_prod;
    logic                          r_s2_valid;
    logic                          r_s2_cmd;
    logic                          r_s2_dir;
    logic [shmc_pkg::QUOT_W-1:0]   r_s2_quot;

    logic                          s1_ready;
    logic                          s2_ready;
    logic [FULL_W-1:0]             full;

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    assign full = FULL_W'(r_s1_prod[shmc_pkg::PROD_W-1:3]) * FULL_W'(shmc_pkg::RECIP_45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_cmd  <= i_cmd;
            r_s1_dir  <= i_direction;
            r_s1_prod <= shmc_pkg::PROD_W'(i_degrees) * shmc_pkg::PROD_W'(i_rev_steps);
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_dir  <= r_s1_dir;
            r_s2_quot <= full[shmc_pkg::RECIP_SHIFT +: shmc_pkg::QUOT_W];
        end
    end

    assign o_valid     = r_s2_valid;
    assign o_cmd       = r_s2_cmd;
    assign o_direction = r_s2_dir;
    assign o_steps     = r_s2_quot;

endmodule

`default_nettype wire

>>> rtl/core/stepper_half_step_move_controller_core.sv
`default_nettype none

// Half-step stepper move controller. A start request (cmd 0) converts whole
// degrees to floor(degrees * steps per revolution / 360) half steps, saturated
// to 20 bits, and is rejected if a move is still running; a tick request
// (cmd 1) counts down the step delay and, when it expires, moves the phase one
// place (down for clockwise, up for counter-clockwise) and counts off one step.
// Every request yields one result carrying the coil pattern and move status.
// A request is taken every cycle while the result side is not stalled; its
// result is presented once it has passed the multiply stage, the
// reciprocal-divide stage and the state-update stage that holds the result
// register. Configuration writes belong in idle periods only.

module stepper_half_step_move_controller_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_cmd,
    input  wire logic                               i_direction,
    input  wire logic [shmc_pkg::DEG_W-1:0]         i_degrees,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [3:0]                              o_coil_pattern,
    output logic                                    o_busy_res,
    output logic [shmc_pkg::STEPS_W-1:0]            o_steps_left,
    output logic                                    o_rejected,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [shmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [shmc_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    logic [shmc_pkg::SPR_W-1:0]    r_rev_steps;
    logic [shmc_pkg::TPS_W-1:0]    r_ticks_per_step;
    logic [2:0]                    r_phase;
    logic [shmc_pkg::STEPS_W-1:0]  r_remaining;
    logic [shmc_pkg::TPS_W-1:0]    r_delay;
    logic                          r_dir;
    logic                          r_out_valid;
    logic [3:0]                    r_coil;
    logic                          r_rejected;

    logic [2:0]                    n_phase;
    logic [shmc_pkg::STEPS_W-1:0]  n_remaining;
    logic [shmc_pkg::TPS_W-1:0]    n_delay;
    logic                          n_dir;
    logic                          n_rejected;
    logic [shmc_pkg::TPS_W-1:0]    delay_dec;
    logic [shmc_pkg::STEPS_W-1:0]  steps_sat;

    logic                          calc_valid;
    logic                          calc_ready;
    logic                          calc_cmd;
    logic                          calc_dir;
    logic [shmc_pkg::QUOT_W-1:0]   calc_steps;
    logic                          take;

    shmc_step_calc u_calc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_direction     (i_direction),
        .i_degrees       (i_degrees),
        .i_rev_steps     (r_rev_steps),
        .o_valid         (calc_valid),
        .i_ready         (calc_ready),
        .o_cmd           (calc_cmd),
        .o_direction     (calc_dir),
        .o_steps         (calc_steps)
    );

    assign calc_ready  = !r_out_valid || i_ready;
    assign take        = calc_valid && calc_ready;
    assign o_cfg_ready = 1'b1;

    assign steps_sat = calc_steps[shmc_pkg::QUOT_W-1] ? shmc_pkg::STEPS_MAX
                                                      : calc_steps[shmc_pkg::STEPS_W-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_delay     = r_delay;
        n_dir       = r_dir;
        n_rejected  = 1'b0;
        delay_dec   = (r_delay != '0) ? r_delay - 1'b1 : r_delay;
        if (calc_cmd == shmc_pkg::CMD_START) begin
            if (r_remaining != '0) begin
                n_rejected = 1'b1;
            end else begin
                n_remaining = steps_sat;
                n_dir       = calc_dir;
                n_delay     = shmc_pkg::TPS_W'(1);
            end
        end else if (r_remaining != '0) begin
            n_delay = delay_dec;
            if (delay_dec == '0) begin
                n_phase     = r_dir ? r_phase + 3'd1 : r_phase - 3'd1;
                n_remaining = r_remaining - 1'b1;
                n_delay     = r_ticks_per_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev_steps      <= shmc_pkg::SPR_RESET;
            r_ticks_per_step <= shmc_pkg::TPS_RESET;
            r_phase          <= '0;
            r_remaining      <= '0;
            r_delay          <= '0;
            r_dir            <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == shmc_pkg::CFG_REV_STEPS) begin
                    r_rev_steps <= i_cfg_data[shmc_pkg::SPR_W-1:0];
                end else if (i_cfg_index == shmc_pkg::CFG_TICKS_PER_STEP) begin
                    r_ticks_per_step <= i_cfg_data[shmc_pkg::TPS_W-1:0];
                end
            end
            if (calc_ready) begin
                r_out_valid <= calc_valid;
            end
            if (take) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_delay     <= n_delay;
                r_dir       <= n_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_coil     <= shmc_pkg::coil_of(n_phase);
            r_rejected <= n_rejected;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_coil_pattern = r_coil;
    assign o_busy_res     = (r_remaining != '0);
    assign o_steps_left   = r_remaining;
    assign o_rejected     = r_rejected;

endmodule

`default_nettype wire

>>> sim/stepper_half_step_move_controller_core_test.sv
module stepper_half_step_move_controller_core_test;

    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 120;

    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    localparam logic [3:0] HALF_STEP_COILS [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    typedef struct packed {
        logic [3:0]                   coil;
        logic                         busy;
        logic [shmc_pkg::STEPS_W-1:0] steps;
        logic                         rejected;
    } t_motor_status;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ
    } t_row_kind;

    typedef struct packed {
        t_row_kind                    kind;
        int                           rep;
        logic                         cmd;
        logic                         dir;
        logic [shmc_pkg::DEG_W-1:0]   deg;
        logic [shmc_pkg::SPR_W-1:0]   spr;
        logic [shmc_pkg::TPS_W-1:0]   tps;
        bit                           fixed;
        t_motor_status                status;
    } t_bench_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic                             i_cmd;
    logic                             i_direction;
    logic [shmc_pkg::DEG_W-1:0]       i_degrees;
    logic                             o_valid;
    logic                             i_ready;
    logic [3:0]                       o_coil_pattern;
    logic                             o_busy_res;
    logic [shmc_pkg::STEPS_W-1:0]     o_steps_left;
    logic                             o_rejected;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [shmc_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [shmc_pkg::CFG_DAT_W-1:0]   i_cfg_data;

    stepper_half_step_move_controller_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_direction    (i_direction),
        .i_degrees      (i_degrees),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_coil_pattern (o_coil_pattern),
        .o_busy_res     (o_busy_res),
        .o_steps_left   (o_steps_left),
        .o_rejected     (o_rejected),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Motor state as the block should hold it after every accepted request.
    logic [shmc_pkg::SPR_W-1:0]   motor_spr;
    logic [shmc_pkg::TPS_W-1:0]   motor_tps;
    logic [2:0]                   motor_phase;
    logic [shmc_pkg::STEPS_W-1:0] motor_steps;
    logic [shmc_pkg::TPS_W-1:0]   motor_delay;
    logic                         motor_ccw;

    t_motor_status      pending_status [$];
    int unsigned        err_count = 0;
    int unsigned        check_count = 0;
    bit                 rst_done = 1'b0;
    bit                 hold_go = 1'b0;

    t_bench_row directed_rows [12] = '{
        '{ROW_REQ, 1, shmc_pkg::CMD_TICK, DIR_CW, 16'd0, 13'd0, 16'd0, 1'b1,
            '{4'h1, 1'b0, 20'd0, 1'b0}},
        '{ROW_REQ, 1, shmc_pkg::CMD_START, DIR_CCW, 16'd0, 13'd0, 16'd0, 1'b1,
            '{4'h1, 1'b0, 20'd0, 1'b0}},
        '{ROW_CFG, 0, shmc_pkg::CMD_TICK, DIR_CW, 16'd0, 13'd4076, 16'd1, 1'b0, '0},
        '{ROW_REQ, 1, shmc_pkg::CMD_START, DIR_CCW, 16'd1, 13'd0, 16'd0, 1'b1,
            '{4'h1, 1'b1, 20'd11, 1'b0}},
        '{ROW_REQ, 1, shmc_pkg::CMD_START, DIR_CW, 16'hFFFF, 13'd0, 16'd0, 1'b1,
            '{4'h1, 1'b1, 20'd11, 1'b1}},
        '{ROW_REQ, 11, shmc_pkg::CMD_TICK, DIR_CCW, 16'd0, 13'd0, 16'd0, 1'b0, '0},
        '{ROW_REQ, 1, shmc_pkg::CMD_TICK, DIR_CW, 16'd0, 13'd0, 16'd0, 1'b0, '0},
        '{ROW_CFG, 0, shmc_pkg::CMD_TICK, DIR_CW, 16'd0, 13'd0, 16'd1, 1'b0, '0},
        '{ROW_REQ, 1, shmc_pkg::CMD_START, DIR_CW, 16'hFFFF, 13'd0, 16'd0, 1'b0, '0},
        '{ROW_CFG, 0, shmc_pkg::CMD_TICK, DIR_CW, 16'd0, 13'd1440, 16'd0, 1'b0, '0},
        '{ROW_REQ, 1, shmc_pkg::CMD_START, DIR_CW, 16'd1, 13'd0, 16'd0, 1'b0, '0},
        '{ROW_REQ, 4, shmc_pkg::CMD_TICK, DIR_CCW, 16'd40000, 13'd0, 16'd0, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(64'd10 * LIMIT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic t_motor_status advance_motor(input logic cmd, input logic dir,
                                                    input logic [shmc_pkg::DEG_W-1:0] deg);
        logic [63:0]   half_steps;
        t_motor_status st;
        st.rejected = 1'b0;
        if (cmd == shmc_pkg::CMD_START) begin
            if (motor_steps != '0) begin
                st.rejected = 1'b1;
            end else begin
                half_steps = (64'(deg) * 64'(motor_spr)) / 64'd360;
                motor_steps = (half_steps > 64'(shmc_pkg::STEPS_MAX))
                              ? shmc_pkg::STEPS_MAX
                              : half_steps[shmc_pkg::STEPS_W-1:0];
                motor_ccw = dir;
                motor_delay = shmc_pkg::TPS_W'(1);
            end
        end else if (motor_steps != '0) begin
            if (motor_delay != '0) begin
                motor_delay = motor_delay - 1'b1;
            end
            // A zero reload behaves like a reload of one.
            if (motor_delay == '0) begin
                motor_phase = motor_ccw ? motor_phase + 3'd1 : motor_phase - 3'd1;
                motor_steps = motor_steps - 1'b1;
                motor_delay = motor_tps;
            end
        end
        st.coil = HALF_STEP_COILS[motor_phase];
        st.busy = (motor_steps != '0);
        st.steps = motor_steps;
        return st;
    endfunction

    task automatic send_request(input logic cmd, input logic dir,
                                input logic [shmc_pkg::DEG_W-1:0] deg,
                                input bit fixed, input t_motor_status fixed_status);
        int unsigned   gap;
        t_motor_status st;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_direction <= dir;
        i_degrees <= deg;
        do @(posedge i_clk); while (!o_ready);
        st = advance_motor(cmd, dir, deg);
        pending_status.push_back(fixed ? fixed_status : st);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both registers are written back to back; the upper data bits above the
    // steps-per-revolution field are junk that the block must drop.
    task automatic set_motor_config(input logic [shmc_pkg::SPR_W-1:0] spr,
                                    input logic [shmc_pkg::TPS_W-1:0] tps);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= shmc_pkg::CFG_REV_STEPS;
        i_cfg_data <= {3'($urandom_range(0, 7)), spr};
        do @(posedge i_clk); while (!o_cfg_ready);
        motor_spr = spr;
        i_cfg_index <= shmc_pkg::CFG_TICKS_PER_STEP;
        i_cfg_data <= tps;
        do @(posedge i_clk); while (!o_cfg_ready);
        motor_tps = tps;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly ticks while a move runs, so moves get to finish; starts then are
    // rejected noise. Wide angles are only started where the move stays short.
    task automatic run_moves(input int unsigned item_count, input int unsigned deg_cap,
                             input bit wide_ok, input bit finish_move);
        int unsigned                r;
        logic                       cmd;
        logic [shmc_pkg::DEG_W-1:0] deg;
        repeat (item_count) begin
            r = $urandom_range(0, 99);
            if (motor_steps != '0) begin
                cmd = (r < 80) ? shmc_pkg::CMD_TICK : shmc_pkg::CMD_START;
            end else begin
                cmd = (r < 45) ? shmc_pkg::CMD_START : shmc_pkg::CMD_TICK;
            end
            r = $urandom_range(0, 99);
            if (r < 25 && (wide_ok || motor_steps != '0)) begin
                deg = shmc_pkg::DEG_W'($urandom);
            end else if (r < 35) begin
                deg = '0;
            end else begin
                deg = shmc_pkg::DEG_W'($urandom_range(0, deg_cap));
            end
            send_request(cmd, 1'($urandom_range(0, 1)), deg, 1'b0, '0);
        end
        while (finish_move && motor_steps != '0) begin
            send_request(shmc_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                         shmc_pkg::DEG_W'($urandom), 1'b0, '0);
        end
    endtask

    initial begin
        int unsigned      ready_run;
        int unsigned      r;
        bit               held;
        t_motor_status    want;
        ready_run = 0;
        held = 1'b0;
        i_ready <= 1'b0;
        wait (rst_done);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_status.size() == 0) begin
                    $error("unexpected result: no request outstanding");
                    err_count++;
                end else begin
                    want = pending_status.pop_front();
                    check_count++;
                    if (o_coil_pattern !== want.coil) begin
                        $error("coil_pattern: expected %h, got %h", want.coil, o_coil_pattern);
                        err_count++;
                    end
                    if (o_busy_res !== want.busy) begin
                        $error("busy_res: expected %b, got %b", want.busy, o_busy_res);
                        err_count++;
                    end
                    if (o_steps_left !== want.steps) begin
                        $error("steps_left: expected %0d, got %0d", want.steps, o_steps_left);
                        err_count++;
                    end
                    if (o_rejected !== want.rejected) begin
                        $error("rejected: expected %b, got %b", want.rejected, o_rejected);
                        err_count++;
                    end
                end
            end
            // One long hold-off while requests keep coming fills the pipeline.
            if (!held && hold_go) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                ready_run = 0;
            end
            if (ready_run != 0) begin
                ready_run--;
            end else if (!i_ready) begin
                i_ready <= 1'b1;
                ready_run = $urandom_range(0, 30);
            end else begin
                i_ready <= 1'b0;
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    ready_run = $urandom_range(0, 2);
                end else if (r < 95) begin
                    ready_run = $urandom_range(3, 10);
                end else begin
                    ready_run = $urandom_range(15, 40);
                end
            end
        end
    end

    initial begin
        t_bench_row                 row;
        logic [shmc_pkg::SPR_W-1:0] spr;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cmd <= shmc_pkg::CMD_TICK;
        i_direction <= DIR_CW;
        i_degrees <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= shmc_pkg::CFG_REV_STEPS;
        i_cfg_data <= '0;
        motor_spr = shmc_pkg::SPR_RESET;
        motor_tps = shmc_pkg::TPS_RESET;
        motor_phase = '0;
        motor_steps = '0;
        motor_delay = '0;
        motor_ccw = DIR_CW;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG) begin
                set_motor_config(row.spr, row.tps);
            end else begin
                repeat (row.rep) send_request(row.cmd, row.dir, row.deg, row.fixed, row.status);
            end
        end

        set_motor_config(13'd1, 16'd1);
        run_moves(120, 720, 1'b1, 1'b1);
        set_motor_config(13'd45, 16'd0);
        // The receiver holds off at the start of this section while requests
        // keep arriving.
        hold_go = 1'b1;
        run_moves(100, 90, 1'b0, 1'b1);
        set_motor_config(13'd360, 16'd3);
        run_moves(100, 12, 1'b0, 1'b1);
        set_motor_config(13'd4076, 16'd1);
        run_moves(90, 3, 1'b0, 1'b1);
        set_motor_config(13'd8191, 16'd1);
        run_moves(80, 2, 1'b0, 1'b1);
        spr = shmc_pkg::SPR_W'($urandom_range(1, 8191));
        set_motor_config(spr, shmc_pkg::TPS_W'($urandom_range(1, 4)));
        run_moves(100, (14400 / spr) + 1, 1'b0, 1'b1);

        // Last: the widest move saturates the step count and never ends here.
        set_motor_config(13'd8191, 16'hFFFF);
        send_request(shmc_pkg::CMD_START, DIR_CCW, 16'hFFFF, 1'b0, '0);
        run_moves(40, 65535, 1'b1, 1'b0);

        wait_results_drained();
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/shmc_pkg.sv
rtl/core/shmc_step_calc.sv
rtl/core/stepper_half_step_move_controller_core.sv
sim/stepper_half_step_move_controller_core_test.sv
